>>> design/lppe_pkg.sv
`timescale 1ns / 1ps

package lppe_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned RGB_BYTES   = 3;
  localparam int unsigned WHITE_BYTES = 4;
  localparam int unsigned PIXEL_W     = WHITE_BYTES * BYTE_BITS;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned TICK_W      = 15;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WHITE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW      = 3'd5;

  typedef struct packed {
    logic [PIXEL_W-1:0] bits;
    logic [COUNT_W-1:0] count;
  } lppe_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
  } lppe_ticks_t;

  typedef struct packed {
    logic       valid;
    lppe_item_t item;
  } lppe_qout_t;

endpackage

>>> design/lppe_front.sv
`timescale 1ns / 1ps

module lppe_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_white,
  input  logic                 white_enable,
  input  logic                 order_select,
  input  logic                 q_full,
  output logic                 push,
  output lppe_pkg::lppe_item_t push_item
);

  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] last_byte;

  assign first_byte  = order_select ? in_red : in_green;
  assign second_byte = order_select ? in_green : in_red;
  assign last_byte   = white_enable ? in_white : 8'h00;

  assign push_item.bits  = {first_byte, second_byte, in_blue, last_byte};
  assign push_item.count = white_enable
      ? lppe_pkg::COUNT_W'(lppe_pkg::WHITE_BYTES * lppe_pkg::BYTE_BITS)
      : lppe_pkg::COUNT_W'(lppe_pkg::RGB_BYTES * lppe_pkg::BYTE_BITS);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

>>> design/lppe_queue.sv
`timescale 1ns / 1ps

module lppe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lppe_pkg::lppe_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output lppe_pkg::lppe_qout_t qout
);

  lppe_pkg::lppe_item_t entry_r [lppe_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'(lppe_pkg::QUEUE_DEPTH));
  assign qout.valid = (count_r != 2'd0);
  assign qout.item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(lppe_pkg::QUEUE_DEPTH))
    else $error("queue holds more entries than its depth");

endmodule

>>> design/lppe_back.sv
`timescale 1ns / 1ps

module lppe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lppe_pkg::lppe_qout_t          qout,
  output logic                          pop,
  input  lppe_pkg::lppe_ticks_t         ticks,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lppe_pkg::TICK_W-1:0]   out_high_ticks,
  output logic [lppe_pkg::TICK_W-1:0]   out_low_ticks,
  output logic                          out_bit_value,
  output logic                          out_pixel_done
);

  logic [lppe_pkg::PIXEL_W-1:0] shift_r, shift_nxt;
  logic [lppe_pkg::COUNT_W-1:0] left_r, left_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         bit_r, bit_nxt;
  logic                         done_r, done_nxt;
  logic [lppe_pkg::TICK_W-1:0]  high_r, high_nxt;
  logic [lppe_pkg::TICK_W-1:0]  low_r, low_nxt;
  logic                         emit_ok;

  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    shift_nxt     = shift_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    bit_nxt       = bit_r;
    done_nxt      = done_r;
    pop           = 1'b0;
    if (emit_ok) begin
      if (left_r != '0) begin
        out_valid_nxt = 1'b1;
        bit_nxt       = shift_r[lppe_pkg::PIXEL_W-1];
        done_nxt      = (left_r == lppe_pkg::COUNT_W'(1));
        shift_nxt     = {shift_r[lppe_pkg::PIXEL_W-2:0], 1'b0};
        left_nxt      = left_r - lppe_pkg::COUNT_W'(1);
      end else if (qout.valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        bit_nxt       = qout.item.bits[lppe_pkg::PIXEL_W-1];
        done_nxt      = (qout.item.count == lppe_pkg::COUNT_W'(1));
        shift_nxt     = {qout.item.bits[lppe_pkg::PIXEL_W-2:0], 1'b0};
        left_nxt      = qout.item.count - lppe_pkg::COUNT_W'(1);
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    high_nxt = bit_nxt ? ticks.one_high : ticks.zero_high;
    low_nxt  = bit_nxt ? ticks.one_low : ticks.zero_low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bit_r   <= bit_nxt;
    done_r  <= done_nxt;
    if (emit_ok) begin
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_value  = bit_r;
  assign out_pixel_done = done_r;
  assign out_high_ticks = high_r;
  assign out_low_ticks  = low_r;

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= lppe_pkg::COUNT_W'(lppe_pkg::PIXEL_W))
    else $error("bit counter exceeds the pixel width");

  a_busy_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> out_valid_r)
    else $error("pixel in progress without a pending symbol");

  a_done_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (left_r == '0))
    else $error("last symbol shown while bits remain");

endmodule

>>> design/led_pixel_pulse_encoder.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | red, green, blue, white (8 bits each)
// out_    | output    | out_valid/out_stall | high_ticks, low_ticks, bit_value, pixel_done
// cfg_    | input     | cfg_we            | cfg_index (3 bits), cfg_wdata
//
// Each pixel yields 24 symbols, or 32 with white enabled, one per cycle from
// the serialiser shift register while the output is not stalled.
// A pixel's first symbol is registered when the serialiser pops it off the queue head.
// A two-entry queue lets pixels be accepted while the serialiser is busy.
// Reset clears the registers, the queue and the serialiser; no clearing pass.
// out_stall freezes the output register and the serialiser; in_stall rises
// only when the queue is full.

module led_pixel_pulse_encoder #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_red,
  input  logic [7:0]                           in_green,
  input  logic [7:0]                           in_blue,
  input  logic [7:0]                           in_white,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lppe_pkg::TICK_W-1:0]          out_high_ticks,
  output logic [lppe_pkg::TICK_W-1:0]          out_low_ticks,
  output logic                                 out_bit_value,
  output logic                                 out_pixel_done,
  input  logic                                 cfg_we,
  input  logic [lppe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [DURATION_BITS-1:0]             cfg_wdata
);

  logic                      white_enable_r;
  logic                      order_select_r;
  logic [DURATION_BITS-1:0]  zero_high_r;
  logic [DURATION_BITS-1:0]  zero_low_r;
  logic [DURATION_BITS-1:0]  one_high_r;
  logic [DURATION_BITS-1:0]  one_low_r;

  lppe_pkg::lppe_ticks_t ticks;
  lppe_pkg::lppe_item_t  push_item;
  lppe_pkg::lppe_qout_t  qout;
  logic                  push;
  logic                  pop;
  logic                  q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_enable_r <= 1'b0;
      order_select_r <= 1'b0;
      zero_high_r    <= '0;
      zero_low_r     <= '0;
      one_high_r     <= '0;
      one_low_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lppe_pkg::REG_WHITE_ENABLE: white_enable_r <= cfg_wdata[0];
        lppe_pkg::REG_ORDER_SELECT: order_select_r <= cfg_wdata[0];
        lppe_pkg::REG_ZERO_HIGH:    zero_high_r    <= cfg_wdata;
        lppe_pkg::REG_ZERO_LOW:     zero_low_r     <= cfg_wdata;
        lppe_pkg::REG_ONE_HIGH:     one_high_r     <= cfg_wdata;
        lppe_pkg::REG_ONE_LOW:      one_low_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign ticks.zero_high = lppe_pkg::TICK_W'(zero_high_r);
  assign ticks.zero_low  = lppe_pkg::TICK_W'(zero_low_r);
  assign ticks.one_high  = lppe_pkg::TICK_W'(one_high_r);
  assign ticks.one_low   = lppe_pkg::TICK_W'(one_low_r);

  lppe_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_white     (in_white),
    .white_enable (white_enable_r),
    .order_select (order_select_r),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  lppe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .qout      (qout)
  );

  lppe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qout           (qout),
    .pop            (pop),
    .ticks          (ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_high_ticks (out_high_ticks),
    .out_low_ticks  (out_low_ticks),
    .out_bit_value  (out_bit_value),
    .out_pixel_done (out_pixel_done)
  );

endmodule

>>> verif/tb_led_pixel_pulse_encoder.sv
`timescale 1ns / 1ps

module tb_led_pixel_pulse_encoder;

  localparam logic [lppe_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [lppe_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PIXELS_PER_PHASE = 61;
  localparam int unsigned TIMEOUT_NS = 10_000_000;

  typedef struct packed {
    logic [lppe_pkg::TICK_W-1:0] high_ticks;
    logic [lppe_pkg::TICK_W-1:0] low_ticks;
    logic                        bit_value;
    logic                        pixel_done;
  } symbol_t;

  class pulse_scoreboard;
    bit                        white_on;
    bit                        order_rgb;
    bit [lppe_pkg::TICK_W-1:0] zero_hi;
    bit [lppe_pkg::TICK_W-1:0] zero_lo;
    bit [lppe_pkg::TICK_W-1:0] one_hi;
    bit [lppe_pkg::TICK_W-1:0] one_lo;
    symbol_t                   expected_symbols[$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               pixels;

    function void write_reg(logic [lppe_pkg::CFG_IDX_W-1:0] idx,
                            logic [lppe_pkg::TICK_W-1:0] data);
      case (idx)
        lppe_pkg::REG_WHITE_ENABLE: white_on = data[0];
        lppe_pkg::REG_ORDER_SELECT: order_rgb = data[0];
        lppe_pkg::REG_ZERO_HIGH:    zero_hi = data;
        lppe_pkg::REG_ZERO_LOW:     zero_lo = data;
        lppe_pkg::REG_ONE_HIGH:     one_hi = data;
        lppe_pkg::REG_ONE_LOW:      one_lo = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] w);
      bit [lppe_pkg::PIXEL_W-1:0] shreg;
      int unsigned                nbits;
      symbol_t                    s;
      shreg = order_rgb ? {r, g, b, 8'h00} : {g, r, b, 8'h00};
      nbits = lppe_pkg::RGB_BYTES * lppe_pkg::BYTE_BITS;
      if (white_on) begin
        shreg[lppe_pkg::BYTE_BITS-1:0] = w;
        nbits = lppe_pkg::WHITE_BYTES * lppe_pkg::BYTE_BITS;
      end
      for (int unsigned i = 0; i < nbits; i++) begin
        s.bit_value  = shreg[lppe_pkg::PIXEL_W-1];
        s.high_ticks = s.bit_value ? one_hi : zero_hi;
        s.low_ticks  = s.bit_value ? one_lo : zero_lo;
        s.pixel_done = (i == nbits - 1);
        expected_symbols.push_back(s);
        shreg = shreg << 1;
      end
      pixels++;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task check_symbol(logic [lppe_pkg::TICK_W-1:0] hi, logic [lppe_pkg::TICK_W-1:0] lo,
                      logic bv, logic done);
      symbol_t e;
      if (expected_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol high %0d low %0d bit %0b last %0b",
                                  hi, lo, bv, done));
      end else begin
        e = expected_symbols.pop_front();
        checked++;
        if (hi !== e.high_ticks) begin
          report_mismatch($sformatf("symbol %0d high_ticks %0d, expected %0d",
                                    checked, hi, e.high_ticks));
        end
        if (lo !== e.low_ticks) begin
          report_mismatch($sformatf("symbol %0d low_ticks %0d, expected %0d",
                                    checked, lo, e.low_ticks));
        end
        if (bv !== e.bit_value) begin
          report_mismatch($sformatf("symbol %0d bit_value %0b, expected %0b",
                                    checked, bv, e.bit_value));
        end
        if (done !== e.pixel_done) begin
          report_mismatch($sformatf("symbol %0d pixel_done %0b, expected %0b",
                                    checked, done, e.pixel_done));
        end
      end
    endtask

    function int unsigned pending();
      return expected_symbols.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_red;
  logic [7:0]                     in_green;
  logic [7:0]                     in_blue;
  logic [7:0]                     in_white;
  logic                           out_valid;
  logic                           out_stall;
  logic [lppe_pkg::TICK_W-1:0]    out_high_ticks;
  logic [lppe_pkg::TICK_W-1:0]    out_low_ticks;
  logic                           out_bit_value;
  logic                           out_pixel_done;
  logic                           cfg_we;
  logic [lppe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lppe_pkg::TICK_W-1:0]    cfg_wdata;

  pulse_scoreboard sb;
  bit              in_gaps;
  bit              stall_random;
  bit              hold_req;
  int unsigned     settings_used;

  led_pixel_pulse_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_white       (in_white),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_high_ticks (out_high_ticks),
    .out_low_ticks  (out_low_ticks),
    .out_bit_value  (out_bit_value),
    .out_pixel_done (out_pixel_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_pixel(in_red, in_green, in_blue, in_white);
      end
      if (out_valid && !out_stall) begin
        sb.check_symbol(out_high_ticks, out_low_ticks, out_bit_value, out_pixel_done);
      end
    end
  end

  // The receiver either runs free, stalls in short bursts, or holds off for a long
  // stretch on request so that the queue fills and the input is stalled.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_random && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d symbols still expected.", sb.pending());
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [lppe_pkg::TICK_W-1:0] rand_ticks();
    logic [lppe_pkg::TICK_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      default: v = lppe_pkg::TICK_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [lppe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lppe_pkg::TICK_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Flag registers get random upper bits, and the two unused indexes are written
  // too; neither may disturb the setting.
  task automatic set_config(input bit white, input bit order,
                            input logic [lppe_pkg::TICK_W-1:0] zh,
                            input logic [lppe_pkg::TICK_W-1:0] zl,
                            input logic [lppe_pkg::TICK_W-1:0] oh,
                            input logic [lppe_pkg::TICK_W-1:0] ol);
    logic [lppe_pkg::TICK_W-2:0] junk_a;
    logic [lppe_pkg::TICK_W-2:0] junk_b;
    junk_a = (lppe_pkg::TICK_W-1)'($urandom);
    junk_b = (lppe_pkg::TICK_W-1)'($urandom);
    write_reg(lppe_pkg::REG_WHITE_ENABLE, {junk_a, white});
    write_reg(lppe_pkg::REG_ORDER_SELECT, {junk_b, order});
    write_reg(lppe_pkg::REG_ZERO_HIGH, zh);
    write_reg(lppe_pkg::REG_ZERO_LOW, zl);
    write_reg(lppe_pkg::REG_ONE_HIGH, oh);
    write_reg(lppe_pkg::REG_ONE_LOW, ol);
    write_reg(REG_SPARE_A, rand_ticks());
    write_reg(REG_SPARE_B, rand_ticks());
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] w);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_white <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = 8'h00;
    in_green  = 8'h00;
    in_blue   = 8'h00;
    in_white  = 8'h00;
    cfg_we    = 1'b0;
    cfg_index = lppe_pkg::REG_WHITE_ENABLE;
    cfg_wdata = '0;
    in_gaps      = 1'b1;
    stall_random = 1'b1;
    hold_req     = 1'b0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all durations are zero.
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
    drain();

    set_config(1'b0, 1'b0, 15'd5, 15'd12, 15'd11, 15'd6);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hA5, 8'h5A);
    send_pixel(8'h80, 8'h01, 8'h80, 8'hFF);
    drain();

    set_config(1'b1, 1'b1, 15'h7FFF, 15'd0, 15'd0, 15'h7FFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h80, 8'h7F, 8'hFE);
    send_pixel(8'h55, 8'hAA, 8'h0F, 8'hF0);
    drain();

    set_config(1'b1, 1'b0, 15'd1, 15'd2, 15'd3, 15'd4);
    send_pixel(8'h11, 8'h22, 8'h33, 8'h44);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    drain();

    set_config(1'b0, 1'b1, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_pixel(8'hC3, 8'h3C, 8'h81, 8'h7E);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
    drain();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        in_gaps      = 1'b0;
        stall_random = 1'b0;
      end
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
      if (phase == 2) begin
        in_gaps  = 1'b0;
        hold_req = 1'b1;
      end
      repeat (PIXELS_PER_PHASE) begin
        send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end
      drain();
      if (phase == 2) begin
        in_gaps = 1'b1;
      end
    end

    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d expected symbols never arrived", sb.pending()));
    end
    $display("Encoded %0d pixels under %0d register settings; %0d pulse symbols compared.",
             sb.pixels, settings_used, sb.checked);
    $display("Covered both byte orders, 24 and 32 bit pixels, zero and full-scale %s%0d%s",
             "durations and a ", HOLD_CYCLES, " cycle output hold-off.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lppe_pkg.sv
design/lppe_front.sv
design/lppe_queue.sv
design/lppe_back.sv
design/led_pixel_pulse_encoder.sv
verif/tb_led_pixel_pulse_encoder.sv
